>>> hdl/jacm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacm_pkg - shared types and constants of the joystick/accelerometer mapper
// Holds the item layouts, the calibration register set, the controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package jacm_pkg;

    // Configuration port geometry: six 32-bit registers at byte address 4*i.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_CAL_OK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STICK_X = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STICK_Y = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_Z = 3'd5;

    localparam logic [23:0] STICK_CAL_RST = 24'h7FFF80;
    localparam logic [19:0] ACCEL_CAL_RST = 20'hAEE00;

    // Axis order of the shared divider.
    localparam int AXIS_W = 3;
    localparam logic [AXIS_W-1:0] AXIS_SX   = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_SY   = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_AX   = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_AY   = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_AZ   = 3'd4;
    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_AZ;

    // Divider: 16 quotient bits, two per cycle.
    localparam int QUO_W        = 16;
    localparam int DIV_BITS     = 2;
    localparam int DIV_CYCLES   = QUO_W / DIV_BITS;
    localparam int ITER_W       = $clog2(DIV_CYCLES);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_CYCLES - 1);
    localparam int OPND_W       = 13;   // signed operand width (values within +/-4092)
    localparam int MAG_W        = 12;   // magnitude of span and offset
    localparam int PROD_W       = MAG_W + QUO_W;

    localparam logic [7:0] STICK_NEG_OFFSET = 8'd127;

    typedef struct packed {
        logic       read_ok;
        logic       button_c_raw;
        logic       button_z_raw;
        logic [7:0] stick_x_raw;
        logic [7:0] stick_y_raw;
        logic [9:0] accel_x_raw;
        logic [9:0] accel_y_raw;
        logic [9:0] accel_z_raw;
    } t_in_item;

    typedef struct packed {
        logic               data_valid;
        logic               button_c;
        logic               button_z;
        logic signed [7:0]  stick_x;
        logic signed [7:0]  stick_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_out_item;

    typedef struct packed {
        logic        calibration_ok;
        logic [23:0] stick_x_cal;
        logic [23:0] stick_y_cal;
        logic [19:0] accel_x_cal;
        logic [19:0] accel_y_cal;
        logic [19:0] accel_z_cal;
    } t_cal;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        KIND_POS,
        KIND_NEG,
        KIND_ACCEL
    } t_kind;

    typedef struct packed {
        logic              capture;
        logic              take_buttons;
        logic              prep;
        logic              load;
        logic              div_step;
        logic              store;
        logic              load_out;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic fresh;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/jacm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacm_regs - calibration register file
// APB-style slave holding the calibration flag and the five packed axis
// calibrations. Writes complete in the access phase; pready is tied high.
// ----------------------------------------------------------------------------
module jacm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jacm_pkg::PADDR_W-1:0]  paddr,
    input  logic [jacm_pkg::PDATA_W-1:0]  pwdata,
    output logic [jacm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output jacm_pkg::t_cal                o_cal
);

    jacm_pkg::t_cal                  r_cal;
    logic [jacm_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[jacm_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.calibration_ok <= 1'b0;
            r_cal.stick_x_cal    <= jacm_pkg::STICK_CAL_RST;
            r_cal.stick_y_cal    <= jacm_pkg::STICK_CAL_RST;
            r_cal.accel_x_cal    <= jacm_pkg::ACCEL_CAL_RST;
            r_cal.accel_y_cal    <= jacm_pkg::ACCEL_CAL_RST;
            r_cal.accel_z_cal    <= jacm_pkg::ACCEL_CAL_RST;
        end else if (wr_en) begin
            case (reg_idx)
                jacm_pkg::REG_CAL_OK:  r_cal.calibration_ok <= pwdata[0];
                jacm_pkg::REG_STICK_X: r_cal.stick_x_cal    <= pwdata[23:0];
                jacm_pkg::REG_STICK_Y: r_cal.stick_y_cal    <= pwdata[23:0];
                jacm_pkg::REG_ACCEL_X: r_cal.accel_x_cal    <= pwdata[19:0];
                jacm_pkg::REG_ACCEL_Y: r_cal.accel_y_cal    <= pwdata[19:0];
                jacm_pkg::REG_ACCEL_Z: r_cal.accel_z_cal    <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            jacm_pkg::REG_CAL_OK:  prdata = {31'd0, r_cal.calibration_ok};
            jacm_pkg::REG_STICK_X: prdata = {8'd0, r_cal.stick_x_cal};
            jacm_pkg::REG_STICK_Y: prdata = {8'd0, r_cal.stick_y_cal};
            jacm_pkg::REG_ACCEL_X: prdata = {12'd0, r_cal.accel_x_cal};
            jacm_pkg::REG_ACCEL_Y: prdata = {12'd0, r_cal.accel_y_cal};
            jacm_pkg::REG_ACCEL_Z: prdata = {12'd0, r_cal.accel_z_cal};
            default:               prdata = '0;
        endcase
    end

    assign o_cal = r_cal;

endmodule

>>> hdl/jacm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacm_ctrl - sequencing controller
// Walks each fresh item through the five axes of the shared divider and
// hands the result of every accepted item to the output register.
// ----------------------------------------------------------------------------
module jacm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  jacm_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output jacm_pkg::t_cmd  o_cmd
);

    jacm_pkg::t_state                r_state, n_state;
    logic [jacm_pkg::AXIS_W-1:0]     r_axis, n_axis;
    logic [jacm_pkg::ITER_W-1:0]     r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jacm_pkg::ST_IDLE;
            r_axis  <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_iter  <= n_iter;
        end
    end

    // Next state and loop counters.
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_iter  = r_iter;
        case (r_state)
            jacm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = jacm_pkg::ST_START;
                end
            end
            jacm_pkg::ST_START: begin
                n_axis  = jacm_pkg::AXIS_SX;
                n_state = i_sts.fresh ? jacm_pkg::ST_PREP : jacm_pkg::ST_FINISH;
            end
            jacm_pkg::ST_PREP: begin
                n_state = jacm_pkg::ST_LOAD;
            end
            jacm_pkg::ST_LOAD: begin
                n_iter  = '0;
                n_state = jacm_pkg::ST_DIV;
            end
            jacm_pkg::ST_DIV: begin
                n_iter = r_iter + 1'b1;
                if (r_iter == jacm_pkg::ITER_LAST) begin
                    n_state = jacm_pkg::ST_STORE;
                end
            end
            jacm_pkg::ST_STORE: begin
                if (r_axis == jacm_pkg::AXIS_LAST) begin
                    n_state = jacm_pkg::ST_FINISH;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = jacm_pkg::ST_PREP;
                end
            end
            jacm_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = jacm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jacm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_in_stall = 1'b1;
        case (r_state)
            jacm_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            jacm_pkg::ST_START:  o_cmd.take_buttons = i_sts.fresh;
            jacm_pkg::ST_PREP:   o_cmd.prep         = 1'b1;
            jacm_pkg::ST_LOAD:   o_cmd.load         = 1'b1;
            jacm_pkg::ST_DIV:    o_cmd.div_step     = 1'b1;
            jacm_pkg::ST_STORE:  o_cmd.store        = 1'b1;
            jacm_pkg::ST_FINISH: o_cmd.load_out     = i_sts.out_free;
            default: begin
            end
        endcase
    end

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jacm_pkg::ST_PREP || r_state == jacm_pkg::ST_LOAD ||
         r_state == jacm_pkg::ST_DIV || r_state == jacm_pkg::ST_STORE)
        |-> (r_axis <= jacm_pkg::AXIS_LAST))
        else $error("axis counter out of range");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jacm_pkg::ST_DIV && r_iter == jacm_pkg::ITER_LAST)
        |=> (r_state == jacm_pkg::ST_STORE))
        else $error("division did not end after its last step");

    a_last_axis_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jacm_pkg::ST_STORE && r_axis == jacm_pkg::AXIS_LAST)
        |=> (r_state == jacm_pkg::ST_FINISH))
        else $error("item did not finish after the last axis");

endmodule

>>> hdl/jacm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacm_dpath - mapping datapath
// Sample register, operand preparation and clamping, a shared restoring
// divider (two quotient bits per cycle), the held result state and the
// output register.
// ----------------------------------------------------------------------------
module jacm_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  jacm_pkg::t_cmd       i_cmd,
    input  jacm_pkg::t_cal       i_cal,
    input  jacm_pkg::t_in_item   i_in_data,
    input  logic                 i_out_stall,
    output jacm_pkg::t_sts       o_sts,
    output logic                 o_out_valid,
    output jacm_pkg::t_out_item  o_out_data
);

    localparam int OW = jacm_pkg::OPND_W;
    localparam int MW = jacm_pkg::MAG_W;
    localparam int QW = jacm_pkg::QUO_W;

    jacm_pkg::t_in_item   r_sample;
    jacm_pkg::t_out_item  r_out_data;
    logic                 r_out_valid;

    logic [1:0]           r_last_buttons;
    logic signed [7:0]    r_stick_x, r_stick_y;
    logic signed [15:0]   r_accel_x, r_accel_y, r_accel_z;

    logic signed [OW-1:0] r_v, r_lo, r_hi;
    jacm_pkg::t_kind      r_kind;
    logic [MW-1:0]        r_rem, r_dvs;
    logic [QW-1:0]        r_quo;
    logic                 r_zero;

    // ---------------- operand preparation ----------------
    logic [7:0]           s_raw, s_mn, s_ctr, s_mx;
    logic [9:0]           a_raw, a_zero, a_one;
    logic                 is_accel;
    logic [8:0]           st_c, st_hi, st_lo;
    logic [10:0]          ac_d, ac_diff;
    logic [11:0]          ac_span2;
    logic signed [OW-1:0] p_v, p_lo, p_hi;
    jacm_pkg::t_kind      p_kind;

    always_comb begin
        s_raw    = '0;
        {s_mx, s_ctr, s_mn} = '0;
        a_raw    = '0;
        {a_one, a_zero} = '0;
        is_accel = 1'b0;
        case (i_cmd.axis)
            jacm_pkg::AXIS_SX: begin
                s_raw = r_sample.stick_x_raw;
                {s_mx, s_ctr, s_mn} = i_cal.stick_x_cal;
            end
            jacm_pkg::AXIS_SY: begin
                s_raw = r_sample.stick_y_raw;
                {s_mx, s_ctr, s_mn} = i_cal.stick_y_cal;
            end
            jacm_pkg::AXIS_AX: begin
                a_raw = r_sample.accel_x_raw;
                {a_one, a_zero} = i_cal.accel_x_cal;
                is_accel = 1'b1;
            end
            jacm_pkg::AXIS_AY: begin
                a_raw = r_sample.accel_y_raw;
                {a_one, a_zero} = i_cal.accel_y_cal;
                is_accel = 1'b1;
            end
            jacm_pkg::AXIS_AZ: begin
                a_raw = r_sample.accel_z_raw;
                {a_one, a_zero} = i_cal.accel_z_cal;
                is_accel = 1'b1;
            end
            default: begin
            end
        endcase

        // Two's complement differences; the extra top bit carries the sign.
        st_c     = {1'b0, s_raw} - {1'b0, s_ctr};
        st_hi    = {1'b0, s_mx} - {1'b0, s_ctr};
        st_lo    = {1'b0, s_mn} - {1'b0, s_ctr};
        ac_d     = {1'b0, a_raw} - {1'b0, a_zero};
        ac_diff  = {1'b0, a_one} - {1'b0, a_zero};
        ac_span2 = {ac_diff, 1'b0};

        if (is_accel) begin
            p_v    = {{2{ac_d[10]}}, ac_d};
            p_hi   = {ac_span2[11], ac_span2};
            p_lo   = '0 - p_hi;
            p_kind = jacm_pkg::KIND_ACCEL;
        end else if (!st_c[8]) begin
            p_v    = {{4{st_c[8]}}, st_c};
            p_lo   = '0;
            p_hi   = {{4{st_hi[8]}}, st_hi};
            p_kind = jacm_pkg::KIND_POS;
        end else begin
            p_v    = {{4{st_c[8]}}, st_c};
            p_lo   = {{4{st_lo[8]}}, st_lo};
            p_hi   = '1;
            p_kind = jacm_pkg::KIND_NEG;
        end
    end

    // ---------------- clamp, span and scaled numerator ----------------
    logic signed [OW-1:0] vc_lo, vc, span, offs;
    logic [MW-1:0]        num_abs, spn_abs;
    logic [jacm_pkg::PROD_W-1:0] prod;

    always_comb begin
        vc_lo   = (r_v < r_lo) ? r_lo : r_v;
        vc      = (vc_lo > r_hi) ? r_hi : vc_lo;
        span    = r_hi - r_lo;
        offs    = vc - r_lo;
        // Offset and span always share their sign, so the quotient is their
        // magnitude ratio.
        num_abs = offs[OW-1] ? MW'(-offs) : offs[MW-1:0];
        spn_abs = span[OW-1] ? MW'(-span) : span[MW-1:0];
        if (r_kind == jacm_pkg::KIND_ACCEL) begin
            prod = {num_abs, {QW{1'b0}}} - {{QW{1'b0}}, num_abs};
        end else begin
            prod = {9'd0, ({num_abs, 7'd0} - {7'd0, num_abs})};
        end
    end

    // ---------------- divider step ----------------
    logic [MW-1:0] d_rem;
    logic [QW-1:0] d_quo;
    logic [MW:0]   d_trial;

    always_comb begin
        d_rem   = r_rem;
        d_quo   = r_quo;
        d_trial = '0;
        for (int k = 0; k < jacm_pkg::DIV_BITS; k++) begin
            d_trial = {d_rem, d_quo[QW-1]};
            if (d_trial >= {1'b0, r_dvs}) begin
                d_rem = MW'(d_trial - {1'b0, r_dvs});
                d_quo = {d_quo[QW-2:0], 1'b1};
            end else begin
                d_rem = d_trial[MW-1:0];
                d_quo = {d_quo[QW-2:0], 1'b0};
            end
        end
    end

    // ---------------- result offset ----------------
    logic [QW-1:0] q_fin;
    logic [7:0]    stick_val;
    logic [15:0]   accel_val;

    always_comb begin
        q_fin     = r_zero ? '0 : r_quo;
        stick_val = (r_kind == jacm_pkg::KIND_NEG) ? (q_fin[7:0] - jacm_pkg::STICK_NEG_OFFSET)
                                                   : q_fin[7:0];
        accel_val = {~q_fin[QW-1], q_fin[QW-2:0]};
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_in_data;
        end
        if (i_cmd.prep) begin
            r_v    <= p_v;
            r_lo   <= p_lo;
            r_hi   <= p_hi;
            r_kind <= p_kind;
        end
        if (i_cmd.load) begin
            r_rem  <= prod[jacm_pkg::PROD_W-1:QW];
            r_quo  <= prod[QW-1:0];
            r_dvs  <= spn_abs;
            r_zero <= (span == '0);
        end else if (i_cmd.div_step) begin
            r_rem <= d_rem;
            r_quo <= d_quo;
        end
        if (i_cmd.load_out) begin
            r_out_data.data_valid <= o_sts.fresh;
            r_out_data.button_c   <= r_last_buttons[0];
            r_out_data.button_z   <= r_last_buttons[1];
            r_out_data.stick_x    <= r_stick_x;
            r_out_data.stick_y    <= r_stick_y;
            r_out_data.accel_x    <= r_accel_x;
            r_out_data.accel_y    <= r_accel_y;
            r_out_data.accel_z    <= r_accel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_buttons <= '0;
            r_stick_x      <= '0;
            r_stick_y      <= '0;
            r_accel_x      <= '0;
            r_accel_y      <= '0;
            r_accel_z      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.take_buttons) begin
                r_last_buttons <= {r_sample.button_z_raw, r_sample.button_c_raw};
            end
            if (i_cmd.store) begin
                case (i_cmd.axis)
                    jacm_pkg::AXIS_SX: r_stick_x <= stick_val;
                    jacm_pkg::AXIS_SY: r_stick_y <= stick_val;
                    jacm_pkg::AXIS_AX: r_accel_x <= accel_val;
                    jacm_pkg::AXIS_AY: r_accel_y <= accel_val;
                    jacm_pkg::AXIS_AZ: r_accel_z <= accel_val;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.fresh    = r_sample.read_ok && i_cal.calibration_ok;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && !r_zero) |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while held");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

>>> hdl/joystick_accel_calibration_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_accel_calibration_mapper_top - controller sample calibration mapper
// Maps one raw controller sample (buttons, two stick axes, three accelerometer
// axes) to calibrated, centered values using the programmed calibration.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall     i_in_data  (t_in_item)
//  out       source     o_out_valid / i_out_stall   o_out_data (t_out_item)
//  config    APB slave  psel, penable, pready       paddr, pwdata, prdata
//
//  A fresh item (read_ok set and calibration valid) runs from its accept
//  through a start state, then for each of the five axes through prepare,
//  load, the divider steps and store, then into the output register once
//  that is free, and back to idle, where the next item is accepted. The
//  shared divider yields two quotient bits per cycle. An item that is not
//  fresh goes from the start state straight to the output register.
//  Reset is synchronous and active low; it restores the calibration defaults
//  and clears the held result values and the output valid flag.
//  The next item is accepted while a finished result waits under i_out_stall;
//  only the hand-over into a still-held output register waits for the stall.
//
// Each stick axis is centered on its calibration center, clamped to the side
// of the center it falls on, and scaled to 0..127 or -127..0. Each
// accelerometer axis is offset by its zero-g reading, clamped to twice the
// one-g span either way and scaled to the full signed 16-bit range. Every
// scaling is a truncating ratio worked out by one restoring divider that is
// shared over the five axes; a span of zero yields the lower limit of the
// output range. When the read failed or the calibration is not valid, the
// previously produced values are repeated with data_valid cleared.
// ----------------------------------------------------------------------------
module joystick_accel_calibration_mapper_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  jacm_pkg::t_in_item            i_in_data,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output jacm_pkg::t_out_item           o_out_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jacm_pkg::PADDR_W-1:0]  paddr,
    input  logic [jacm_pkg::PDATA_W-1:0]  pwdata,
    output logic [jacm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // Calibration registers feed the datapath directly; the user is to
    // change them only while the block is idle; the block does not enforce it.
    jacm_pkg::t_cal  cal;

    // Command and status bundles between the controller and the datapath.
    jacm_pkg::t_cmd  cmd;
    jacm_pkg::t_sts  sts;

    jacm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (cal)
    );

    // The controller steps each item through the axes and decides whether
    // the item is converted or only repeats the held values.
    jacm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the sample, the shared divider, the held results
    // and the output register that parts the two channels.
    jacm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cal       (cal),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/joystick_accel_calibration_mapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_accel_calibration_mapper_top_tb - self-checking bench of the mapper
// Programs the calibration registers over the APB port, streams raw controller
// samples through the input channel and checks every calibrated result against
// a behavioral mapper kept in the bench. Directed cases come first, then
// random traffic under three idling patterns and several calibration sets.
// ----------------------------------------------------------------------------
module joystick_accel_calibration_mapper_top_tb;

    import jacm_pkg::*;

    // The run is stopped here if the block hangs; the limit counts every cycle
    // of the whole run, since the watchdog count is never reset.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_ITEMS  = 154;

    // Register slots past the end of the map; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Output ranges of the linear maps.
    localparam int STICK_FULL    = 127;
    localparam int ACCEL_OUT_MIN = -32768;
    localparam int ACCEL_OUT_MAX = 32767;

    // How a random phase chooses its calibration set.
    typedef enum int {
        CAL_TYPICAL,
        CAL_EXTREME,
        CAL_ARBITRARY
    } cal_style_e;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    joystick_accel_calibration_mapper_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state: the calibration as programmed, the values the mapper last
    // produced, and the calibrated samples still owed by the block.
    // ------------------------------------------------------------------------
    t_cal               cal_shadow;
    logic [1:0]         held_buttons = '0;
    logic signed [7:0]  held_sticks [2];
    logic signed [15:0] held_accels [3];
    t_out_item          expected_samples [$];

    int send_idle_pct = 23;
    int recv_idle_pct = 73;
    int stall_burst   = 0;

    int cycle_count    = 0;
    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int fresh_results  = 0;

    // ------------------------------------------------------------------------
    // Behavioral mapper
    // ------------------------------------------------------------------------

    // Clamp v into [lo, hi] and scale it onto [olo, ohi]. The upper clamp is
    // applied last, so a reversed interval lands on the upper output limit.
    // Division truncates toward zero; an empty span gives the lower limit.
    function automatic int span_map(input int v, input int lo, input int hi,
                                    input int olo, input int ohi);
        longint span;
        longint num;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        span = longint'(hi) - longint'(lo);
        if (span == 0) return olo;
        num = (longint'(v) - longint'(lo)) * (longint'(ohi) - longint'(olo));
        return int'(num / span + longint'(olo));
    endfunction

    // A stick sample is taken relative to its center and scaled on the side
    // of the center that it falls on.
    function automatic logic signed [7:0] stick_position(input logic [7:0] raw,
                                                         input logic [23:0] cal);
        int lo_pt;
        int mid;
        int hi_pt;
        int c;
        lo_pt = int'(cal[7:0]);
        mid   = int'(cal[15:8]);
        hi_pt = int'(cal[23:16]);
        c     = int'(raw) - mid;
        if (c >= 0) return 8'(span_map(c, 0, hi_pt - mid, 0, STICK_FULL));
        return 8'(span_map(c, lo_pt - mid, -1, -STICK_FULL, 0));
    endfunction

    // An accelerometer sample is offset by its zero-g reading and scaled so
    // that twice the one-g span either way covers the 16-bit range.
    function automatic logic signed [15:0] accel_level(input logic [9:0] raw,
                                                       input logic [19:0] cal);
        int zero_g;
        int one_g;
        int d;
        int span2;
        zero_g = int'(cal[9:0]);
        one_g  = int'(cal[19:10]);
        d      = int'(raw) - zero_g;
        span2  = (one_g - zero_g) * 2;
        return 16'(span_map(d, -span2, span2, ACCEL_OUT_MIN, ACCEL_OUT_MAX));
    endfunction

    // One accepted sample gives one result. The held values only move when
    // the read succeeded and the calibration is valid.
    function automatic t_out_item calibrate_sample(input t_in_item s);
        t_out_item r;
        logic      fresh;
        fresh = s.read_ok && cal_shadow.calibration_ok;
        if (fresh) begin
            held_buttons   = {s.button_z_raw, s.button_c_raw};
            held_sticks[0] = stick_position(s.stick_x_raw, cal_shadow.stick_x_cal);
            held_sticks[1] = stick_position(s.stick_y_raw, cal_shadow.stick_y_cal);
            held_accels[0] = accel_level(s.accel_x_raw, cal_shadow.accel_x_cal);
            held_accels[1] = accel_level(s.accel_y_raw, cal_shadow.accel_y_cal);
            held_accels[2] = accel_level(s.accel_z_raw, cal_shadow.accel_z_cal);
        end
        r.data_valid = fresh;
        r.button_c   = held_buttons[0];
        r.button_z   = held_buttons[1];
        r.stick_x    = held_sticks[0];
        r.stick_y    = held_sticks[1];
        r.accel_x    = held_accels[0];
        r.accel_y    = held_accels[1];
        r.accel_z    = held_accels[2];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // One APB write: setup cycle, access cycle, then an idle cycle so that a
    // following write never touches psel twice in one time step.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CAL_OK:  cal_shadow.calibration_ok = value[0];
            REG_STICK_X: cal_shadow.stick_x_cal    = value[23:0];
            REG_STICK_Y: cal_shadow.stick_y_cal    = value[23:0];
            REG_ACCEL_X: cal_shadow.accel_x_cal    = value[19:0];
            REG_ACCEL_Y: cal_shadow.accel_y_cal    = value[19:0];
            REG_ACCEL_Z: cal_shadow.accel_z_cal    = value[19:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all six registers with the calibration used by most directed cases.
    task automatic program_base_cal();
        write_reg(REG_CAL_OK,  32'd1);
        write_reg(REG_STICK_X, 32'hE08020);
        write_reg(REG_STICK_Y, 32'hF07010);
        write_reg(REG_ACCEL_X, {12'd0, 10'd700, 10'd500});
        write_reg(REG_ACCEL_Y, {12'd0, 10'd600, 10'd400});
        write_reg(REG_ACCEL_Z, {12'd0, 10'd900, 10'd512});
    endtask

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------

    // Presents one item and holds it until accepted. An optional gap is put in
    // front; most gaps are short, a few are long enough to land anywhere in
    // the block's conversion of an item.
    task automatic send_sample(input t_in_item s);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(0, 70)) @(negedge i_clk);
            else repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        expected_samples.push_back(calibrate_sample(s));
        items_sent++;
    endtask

    // Lowers valid and waits until every owed result has been checked.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in_item make_sample(input logic ok, input logic c, input logic z,
                                             input logic [7:0] sx, input logic [7:0] sy,
                                             input logic [9:0] ax, input logic [9:0] ay,
                                             input logic [9:0] az);
        t_in_item s;
        s.read_ok      = ok;
        s.button_c_raw = c;
        s.button_z_raw = z;
        s.stick_x_raw  = sx;
        s.stick_y_raw  = sy;
        s.accel_x_raw  = ax;
        s.accel_y_raw  = ay;
        s.accel_z_raw  = az;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int jitter();
        return int'($urandom_range(0, 2)) - 1;
    endfunction

    // Stick readings: a share sits on or next to a calibration point, the rest
    // is spread over the whole 8-bit range.
    function automatic logic [7:0] stick_probe(input logic [23:0] cal);
        case ($urandom_range(0, 7))
            0:       return 8'(int'(cal[7:0]) + jitter());
            1:       return 8'(int'(cal[15:8]) + jitter());
            2:       return 8'(int'(cal[23:16]) + jitter());
            default: return 8'($urandom);
        endcase
    endfunction

    // Accelerometer readings: near zero g, near the two clamp points, or anywhere.
    function automatic logic [9:0] accel_probe(input logic [19:0] cal);
        int zero_g;
        int span2;
        zero_g = int'(cal[9:0]);
        span2  = 2 * (int'(cal[19:10]) - zero_g);
        case ($urandom_range(0, 7))
            0:       return 10'(zero_g + jitter());
            1:       return 10'(zero_g + span2 + jitter());
            2:       return 10'(zero_g - span2 + jitter());
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_sample();
        t_in_item s;
        s.read_ok      = ($urandom_range(0, 9) != 0);
        s.button_c_raw = 1'($urandom);
        s.button_z_raw = 1'($urandom);
        s.stick_x_raw  = stick_probe(cal_shadow.stick_x_cal);
        s.stick_y_raw  = stick_probe(cal_shadow.stick_y_cal);
        s.accel_x_raw  = accel_probe(cal_shadow.accel_x_cal);
        s.accel_y_raw  = accel_probe(cal_shadow.accel_y_cal);
        s.accel_z_raw  = accel_probe(cal_shadow.accel_z_cal);
        return s;
    endfunction

    function automatic logic [31:0] stick_cal_for(input cal_style_e style);
        int lo_pt;
        int mid;
        int hi_pt;
        lo_pt = 0;
        mid   = 0;
        hi_pt = 0;
        case (style)
            CAL_TYPICAL: begin
                lo_pt = $urandom_range(0, 120);
                mid   = lo_pt + $urandom_range(1, 100);
                hi_pt = mid + $urandom_range(1, 255 - mid);
            end
            CAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: begin lo_pt = 0;   mid = 128; hi_pt = 255; end
                    1: begin lo_pt = 0;   mid = 0;   hi_pt = 255; end
                    2: begin lo_pt = 0;   mid = 255; hi_pt = 255; end
                    default: begin lo_pt = 255; mid = 0; hi_pt = 0; end
                endcase
            end
            default: return {8'd0, 24'($urandom)};
        endcase
        return {8'd0, 8'(hi_pt), 8'(mid), 8'(lo_pt)};
    endfunction

    function automatic logic [31:0] accel_cal_for(input cal_style_e style);
        int zero_g;
        int one_g;
        zero_g = 0;
        one_g  = 0;
        case (style)
            CAL_TYPICAL: begin
                zero_g = $urandom_range(200, 700);
                one_g  = zero_g + $urandom_range(1, 300);
            end
            CAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: begin zero_g = 0;    one_g = 1023; end
                    1: begin zero_g = 1023; one_g = 0;    end
                    2: begin zero_g = 512;  one_g = 512;  end
                    default: begin zero_g = 0; one_g = 1; end
                endcase
            end
            default: return {12'd0, 20'($urandom)};
        endcase
        return {12'd0, 10'(one_g), 10'(zero_g)};
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the calibration is invalid, so results repeat the cleared
    // values as invalid. Enabling it alone then exercises the default sets.
    task automatic test_reset_defaults();
        send_sample(make_sample(1'b1, 1'b1, 1'b1, 8'd200, 8'd30, 10'd900, 10'd5, 10'd512));
        send_sample(random_sample());
        wait_drained();
        write_reg(REG_CAL_OK, 32'd1);
        send_sample(make_sample(1'b1, 1'b1, 1'b0, 8'd255, 8'd0, 10'd1023, 10'd0, 10'd699));
        send_sample(random_sample());
        wait_drained();
    endtask

    // Field extremes, the center, the calibration end points and the clamp points.
    task automatic test_field_extremes();
        program_base_cal();
        send_sample(make_sample(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 10'd0, 10'd0, 10'd0));
        send_sample(make_sample(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 10'd1023, 10'd1023, 10'd1023));
        send_sample(make_sample(1'b1, 1'b1, 1'b0, 8'h80, 8'h70, 10'd500, 10'd400, 10'd512));
        send_sample(make_sample(1'b1, 1'b0, 1'b1, 8'h20, 8'h10, 10'd100, 10'd0, 10'd112));
        send_sample(make_sample(1'b1, 1'b1, 1'b1, 8'hE0, 8'hF0, 10'd900, 10'd800, 10'd1023));
        send_sample(make_sample(1'b1, 1'b0, 1'b0, 8'h81, 8'h6F, 10'd501, 10'd399, 10'd511));
        wait_drained();
    endtask

    // An empty span yields the lower output limit: X has min one below the
    // center, Y has max equal to the center, accel X has one-g equal to zero-g.
    task automatic test_zero_span();
        write_reg(REG_STICK_X, 32'hC0807F);
        write_reg(REG_STICK_Y, 32'h808010);
        write_reg(REG_ACCEL_X, {12'd0, 10'd500, 10'd500});
        send_sample(make_sample(1'b1, 1'b1, 1'b0, 8'h7F, 8'h80, 10'd0, 10'd400, 10'd512));
        send_sample(make_sample(1'b1, 1'b0, 1'b1, 8'h00, 8'hFF, 10'd1023, 10'd10, 10'd7));
        send_sample(make_sample(1'b1, 1'b1, 1'b1, 8'h80, 8'h40, 10'd500, 10'd990, 10'd1000));
        wait_drained();
    endtask

    // Reversed intervals clamp to the upper limit: min above center, max below
    // center, and accel axes whose one-g reading lies below zero-g.
    task automatic test_reversed_interval();
        write_reg(REG_STICK_X, 32'h408090);
        write_reg(REG_STICK_Y, 32'h5060A0);
        write_reg(REG_ACCEL_X, {12'd0, 10'd400, 10'd600});
        write_reg(REG_ACCEL_Y, {12'd0, 10'd0, 10'd1023});
        send_sample(make_sample(1'b1, 1'b0, 1'b0, 8'hF0, 8'hF0, 10'd1023, 10'd1023, 10'd600));
        send_sample(make_sample(1'b1, 1'b1, 1'b0, 8'h10, 8'h10, 10'd0, 10'd0, 10'd300));
        send_sample(make_sample(1'b1, 1'b0, 1'b1, 8'h80, 8'h60, 10'd600, 10'd512, 10'd900));
        wait_drained();
    endtask

    // A failed read, and then an invalid calibration, repeat the held values
    // with data_valid cleared and leave them unchanged.
    task automatic test_failed_read_hold();
        program_base_cal();
        send_sample(make_sample(1'b1, 1'b1, 1'b0, 8'hB0, 8'h30, 10'd650, 10'd300, 10'd700));
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 8'h10, 8'hE0, 10'd5, 10'd1000, 10'd20));
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 8'hFF, 8'h00, 10'd1023, 10'd0, 10'd0));
        wait_drained();
        write_reg(REG_CAL_OK, 32'd0);
        send_sample(make_sample(1'b1, 1'b0, 1'b1, 8'h00, 8'hFF, 10'd0, 10'd1023, 10'd1023));
        wait_drained();
        write_reg(REG_CAL_OK, 32'd1);
    endtask

    // Writes past the end of the register map must leave the calibration alone.
    task automatic test_unmapped_register();
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'h0000_0000);
        send_sample(random_sample());
        send_sample(random_sample());
        wait_drained();
    endtask

    // Random traffic under one idling pattern, over a typical, an extreme and
    // an arbitrary calibration set. Every register is rewritten per set.
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        cal_style_e style;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int p = 0; p < 3; p++) begin
            style = cal_style_e'(p);
            write_reg(REG_CAL_OK, (style == CAL_ARBITRARY) ? 32'($urandom_range(0, 3) != 0)
                                                           : 32'd1);
            write_reg(REG_STICK_X, stick_cal_for(style));
            write_reg(REG_STICK_Y, stick_cal_for(style));
            write_reg(REG_ACCEL_X, accel_cal_for(style));
            write_reg(REG_ACCEL_Y, accel_cal_for(style));
            write_reg(REG_ACCEL_Z, accel_cal_for(style));
            repeat (RANDOM_ITEMS) send_sample(random_sample());
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: receiver stalls and the result checker
    // ------------------------------------------------------------------------

    // The receiver stalls per cycle at the current rate, and now and then holds
    // off for a long burst so that a finished result waits and the input backs up.
    always @(negedge i_clk) begin
        if (stall_burst != 0) begin
            i_out_stall <= 1'b1;
            stall_burst = stall_burst - 1;
        end else if (recv_idle_pct != 0 && $urandom_range(0, 199) == 0) begin
            stall_burst = $urandom_range(20, 120);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result is matched against the oldest owed sample.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_out_data);
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                compare_field("data_valid", want.data_valid, o_out_data.data_valid);
                compare_field("button_c",   want.button_c,   o_out_data.button_c);
                compare_field("button_z",   want.button_z,   o_out_data.button_z);
                compare_field("stick_x",    want.stick_x,    o_out_data.stick_x);
                compare_field("stick_y",    want.stick_y,    o_out_data.stick_y);
                compare_field("accel_x",    want.accel_x,    o_out_data.accel_x);
                compare_field("accel_y",    want.accel_y,    o_out_data.accel_y);
                compare_field("accel_z",    want.accel_z,    o_out_data.accel_z);
                results_seen++;
                if (want.data_valid) fresh_results++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                     expected_samples.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        // The bench copy of the registers starts from the reset defaults.
        cal_shadow.calibration_ok = 1'b0;
        cal_shadow.stick_x_cal    = STICK_CAL_RST;
        cal_shadow.stick_y_cal    = STICK_CAL_RST;
        cal_shadow.accel_x_cal    = ACCEL_CAL_RST;
        cal_shadow.accel_y_cal    = ACCEL_CAL_RST;
        cal_shadow.accel_z_cal    = ACCEL_CAL_RST;
        held_sticks[0] = '0;
        held_sticks[1] = '0;
        held_accels[0] = '0;
        held_accels[1] = '0;
        held_accels[2] = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases run with the first idling pattern.
        test_reset_defaults();
        test_field_extremes();
        test_zero_span();
        test_reversed_interval();
        test_failed_read_hold();
        test_unmapped_register();

        test_random_traffic(23, 73);
        test_random_traffic(73, 23);
        test_random_traffic(0, 0);

        // Nothing is owed now; give the block time to show any stray result.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples: directed edge cases plus nine random calibration sets",
                 items_sent);
        $display("under three idling patterns; checked %0d results, %0d of them fresh.",
                 results_seen, fresh_results);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
